// ----- src/atan2_approx_core_assert.svh -----
// Assertion macros shared by the atan2 approximation core and its divider.
// Both expect aclk and aresetn (synchronous, active low) in the enclosing scope.
`ifndef ATAN2_APPROX_CORE_ASSERT_SVH
`define ATAN2_APPROX_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define A2A_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define A2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/a2a_pkg.sv -----
// Package for the atan2 approximation core: fixed-point constants, widths
// and the per-item control flags carried down the pipeline. No dependencies.
package a2a_pkg;

    localparam int IN_WIDTH_DEF = 16;
    localparam int OUT_WIDTH    = 17;
    localparam int OUT_TDATA_W  = 24;

    localparam int Q12_PI_4    = 3217;
    localparam int Q12_PI_4_SH = 3217 * 4096;
    localparam int Q12_PI_2    = 6434;
    localparam int Q12_PI      = 12868;
    localparam int C309_Q16    = 20251;
    localparam int ROUND_HALF  = 2048;
    localparam int FRAC_SHIFT  = 12;

    localparam int OUT_MIN = -65536;
    localparam int OUT_MAX = 65535;

    typedef struct packed {
        logic yneg;
        logic xneg;
        logic swapped;
        logic zero;
    } ctl_t;

endpackage

// ----- src/a2a_div.sv -----
// Pipelined restoring divider, one quotient bit per stage, with valid bits
// and control flags carried alongside. Depends on a2a_pkg and the assert header.
`include "atan2_approx_core_assert.svh"

module a2a_div #(
    parameter int MW = a2a_pkg::IN_WIDTH_DEF,
    parameter int KW = a2a_pkg::IN_WIDTH_DEF + 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [MW+KW-1:0]    in_num,
    input  logic [MW-1:0]       in_den,
    input  a2a_pkg::ctl_t       in_ctl,
    output logic                out_vld,
    output logic [KW-1:0]       out_quo,
    output a2a_pkg::ctl_t       out_ctl
);

    logic [KW:0]         vld_reg;
    logic [MW-1:0]       rem_reg [KW+1];
    logic [KW-1:0]       nq_reg  [KW+1];
    logic [MW-1:0]       den_reg [KW+1];
    a2a_pkg::ctl_t       ctl_reg [KW+1];

    logic [MW:0]         trial [KW];
    logic [KW-1:0]       ge;
    logic [MW-1:0]       rem_next [KW];
    logic [KW-1:0]       nq_next  [KW];

    // remainder stays below the divisor, so the trial fits MW+1 bits
    always_comb begin
        for (int i = 0; i < KW; i++) begin
            trial[i]    = {rem_reg[i], nq_reg[i][KW-1]};
            ge[i]       = (trial[i] >= {1'b0, den_reg[i]});
            rem_next[i] = ge[i] ? MW'(trial[i] - {1'b0, den_reg[i]}) : trial[i][MW-1:0];
            nq_next[i]  = {nq_reg[i][KW-2:0], ge[i]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[KW-1:0], in_vld};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= in_num[MW+KW-1:KW];
            nq_reg[0]  <= in_num[KW-1:0];
            den_reg[0] <= in_den;
            ctl_reg[0] <= in_ctl;
            for (int i = 0; i < KW; i++) begin
                rem_reg[i+1] <= rem_next[i];
                nq_reg[i+1]  <= nq_next[i];
                den_reg[i+1] <= den_reg[i];
                ctl_reg[i+1] <= ctl_reg[i];
            end
        end
    end

    assign out_vld = vld_reg[KW];
    assign out_quo = nq_reg[KW];
    assign out_ctl = ctl_reg[KW];

    for (genvar g = 0; g <= KW; g++) begin : g_chk
        `A2A_ASSERT_IMPLIES(a_rem_below_den, vld_reg[g] && (den_reg[g] != '0), rem_reg[g] < den_reg[g], "divider remainder not below divisor")
    end

    `A2A_ASSERT_NEXT(a_div_stall_hold, !en, $stable(vld_reg), "divider valid bits moved during stall")

endmodule

// ----- src/atan2_approx_core.sv -----
// Top level of the atan2 approximation core: octant reduction, rational
// angle term, divider and quadrant mapping. Depends on a2a_pkg and a2a_div.
//
// Takes (y, x) in signed Q7.8 and returns the angle in signed Q4.12 radians.
// One transfer per cycle in and out when not stalled. The pipeline has four
// front stages, the divider's input register plus one stage per quotient bit
// (IN_WIDTH + 16 bits), and three back stages.
// The bit-per-stage divider sets the depth. A stall on m_tready freezes the
// whole pipeline; s_tready follows it in the same cycle.
`include "atan2_approx_core_assert.svh"

module atan2_approx_core #(
    parameter int IN_WIDTH = a2a_pkg::IN_WIDTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((2*IN_WIDTH+7)/8)*8-1:0]       s_tdata,   // y_in, x_in
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [a2a_pkg::OUT_TDATA_W-1:0]       m_tdata    // angle_out
);

    localparam int MW = IN_WIDTH;
    localparam int KW = IN_WIDTH + 16;
    localparam int KH = KW - 16;
    localparam int NW = MW + KW;
    localparam int AW = KW - 11;
    localparam int RW = AW + 4;
    localparam int OW = a2a_pkg::OUT_WIDTH;

    localparam logic [KW-1:0] PI4_K = KW'(a2a_pkg::Q12_PI_4_SH);
    localparam logic [KW-1:0] C309_K = KW'(a2a_pkg::C309_Q16);
    localparam logic signed [RW-1:0] PI2_R = RW'(a2a_pkg::Q12_PI_2);
    localparam logic signed [RW-1:0] PI_R = RW'(a2a_pkg::Q12_PI);
    localparam logic signed [RW-1:0] MIN_R = RW'(a2a_pkg::OUT_MIN);
    localparam logic signed [RW-1:0] MAX_R = RW'(a2a_pkg::OUT_MAX);

    logic en;

    logic [IN_WIDTH-1:0] y_raw, x_raw;

    // stage 1: magnitudes
    logic                s1_vld_reg;
    logic [MW-1:0]       s1_ay_reg, s1_ax_reg;
    a2a_pkg::ctl_t       s1_ctl_reg;

    // stage 2: octant reduction
    logic                s2_vld_reg;
    logic [MW-1:0]       s2_mn_reg, s2_mx_reg, s2_diff_reg;
    a2a_pkg::ctl_t       s2_ctl_reg, s2_ctl_next;

    // stage 3: numerator factor k
    logic                s3_vld_reg;
    logic [MW-1:0]       s3_mn_reg, s3_mx_reg;
    logic [KW-1:0]       s3_k_reg;
    a2a_pkg::ctl_t       s3_ctl_reg;

    // stage 4: partial products of mn * k
    logic                s4_vld_reg;
    logic [MW+15:0]      s4_pp_lo_reg;
    logic [MW+KH-1:0]    s4_pp_hi_reg;
    logic [MW-1:0]       s4_mx_reg;
    a2a_pkg::ctl_t       s4_ctl_reg;

    logic [NW-1:0]       num_next;

    logic                div_vld;
    logic [KW-1:0]       div_quo;
    a2a_pkg::ctl_t       div_ctl;

    // back stages
    logic                f1_vld_reg;
    logic [AW-1:0]       f1_a_reg;
    a2a_pkg::ctl_t       f1_ctl_reg;
    logic [KW:0]         round_sum;

    logic                f2_vld_reg;
    logic signed [RW-1:0] f2_oct_reg, oct_next, a_ext;
    a2a_pkg::ctl_t       f2_ctl_reg;

    logic                m_tvalid_reg;
    logic [OW-1:0]       angle_reg, angle_next;
    logic signed [RW-1:0] signed_val;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;

    assign y_raw = s_tdata[IN_WIDTH-1:0];
    assign x_raw = s_tdata[2*IN_WIDTH-1:IN_WIDTH];

    always_comb begin
        s2_ctl_next         = s1_ctl_reg;
        s2_ctl_next.swapped = (s1_ax_reg < s1_ay_reg);
        s2_ctl_next.zero    = (s1_ax_reg == '0) && (s1_ay_reg == '0);
    end

    assign num_next = {s4_pp_hi_reg, 16'b0} + NW'(s4_pp_lo_reg);

    assign round_sum = {1'b0, div_quo} + (KW+1)'(a2a_pkg::ROUND_HALF);

    assign a_ext = $signed({{(RW-AW){1'b0}}, f1_a_reg});

    always_comb begin
        case ({f1_ctl_reg.xneg, f1_ctl_reg.swapped})
            2'b00:   oct_next = a_ext;
            2'b01:   oct_next = PI2_R - a_ext;
            2'b10:   oct_next = PI_R - a_ext;
            2'b11:   oct_next = PI2_R + a_ext;
            default: oct_next = a_ext;
        endcase
    end

    always_comb begin
        signed_val = f2_ctl_reg.yneg ? -f2_oct_reg : f2_oct_reg;
        if (f2_ctl_reg.zero) begin
            angle_next = '0;
        end else if (signed_val < MIN_R) begin
            angle_next = MIN_R[OW-1:0];
        end else if (signed_val > MAX_R) begin
            angle_next = MAX_R[OW-1:0];
        end else begin
            angle_next = signed_val[OW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s3_vld_reg   <= 1'b0;
            s4_vld_reg   <= 1'b0;
            f1_vld_reg   <= 1'b0;
            f2_vld_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            s1_vld_reg   <= s_tvalid;
            s2_vld_reg   <= s1_vld_reg;
            s3_vld_reg   <= s2_vld_reg;
            s4_vld_reg   <= s3_vld_reg;
            f1_vld_reg   <= div_vld;
            f2_vld_reg   <= f1_vld_reg;
            m_tvalid_reg <= f2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_ay_reg          <= y_raw[IN_WIDTH-1] ? MW'(-y_raw) : y_raw;
            s1_ax_reg          <= x_raw[IN_WIDTH-1] ? MW'(-x_raw) : x_raw;
            s1_ctl_reg.yneg    <= y_raw[IN_WIDTH-1];
            s1_ctl_reg.xneg    <= x_raw[IN_WIDTH-1];
            s1_ctl_reg.swapped <= 1'b0;
            s1_ctl_reg.zero    <= 1'b0;

            s2_mn_reg   <= s2_ctl_next.swapped ? s1_ax_reg : s1_ay_reg;
            s2_mx_reg   <= s2_ctl_next.swapped ? s1_ay_reg : s1_ax_reg;
            s2_diff_reg <= s2_ctl_next.swapped ? MW'(s1_ay_reg - s1_ax_reg)
                                               : MW'(s1_ax_reg - s1_ay_reg);
            s2_ctl_reg  <= s2_ctl_next;

            s3_k_reg   <= PI4_K + KW'(C309_K * KW'(s2_diff_reg));
            s3_mn_reg  <= s2_mn_reg;
            s3_mx_reg  <= s2_mx_reg;
            s3_ctl_reg <= s2_ctl_reg;

            s4_pp_lo_reg <= (MW+16)'(s3_mn_reg) * (MW+16)'(s3_k_reg[15:0]);
            s4_pp_hi_reg <= (MW+KH)'(s3_mn_reg) * (MW+KH)'(s3_k_reg[KW-1:16]);
            s4_mx_reg    <= s3_mx_reg;
            s4_ctl_reg   <= s3_ctl_reg;

            f1_a_reg   <= round_sum[KW:a2a_pkg::FRAC_SHIFT];
            f1_ctl_reg <= div_ctl;

            f2_oct_reg <= oct_next;
            f2_ctl_reg <= f1_ctl_reg;

            angle_reg <= angle_next;
        end
    end

    a2a_div #(
        .MW (MW),
        .KW (KW)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .en      (en),
        .in_vld  (s4_vld_reg),
        .in_num  (num_next),
        .in_den  (s4_mx_reg),
        .in_ctl  (s4_ctl_reg),
        .out_vld (div_vld),
        .out_quo (div_quo),
        .out_ctl (div_ctl)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(a2a_pkg::OUT_TDATA_W-OW){1'b0}}, angle_reg};

    `A2A_ASSERT_NEXT(a_stall_hold, !en, $stable({s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg, f1_vld_reg, f2_vld_reg, m_tvalid_reg}), "pipeline valid bits moved during stall")

    `A2A_ASSERT_IMPLIES(a_octant_order, s2_vld_reg && !s2_ctl_reg.zero, (s2_mn_reg <= s2_mx_reg) && (s2_mx_reg != '0), "octant reduction gave min above max")

    `A2A_ASSERT_IMPLIES(a_k_floor, s3_vld_reg, s3_k_reg >= PI4_K, "numerator factor below pi/4 term")

endmodule
